[hdl/falt_pkg.sv]
// Package for the failed-attempt lockout timer: item types, opcodes, register
// indexes, reset values and the status/control structs between the core and
// the delay tracker. No dependencies.
`default_nettype none

package falt_pkg;

    // Time width default; the top level carries it as a parameter.
    localparam int TIME_BITS_DEF = 48;
    localparam int NOW_W         = 48;

    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;

    // Opcodes
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_QUERY = 2'd0;
    localparam t_opcode OP_FAIL  = 2'd1;
    localparam t_opcode OP_RESET = 2'd2;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ENABLED       = 2'd0;
    localparam t_cfg_idx CFG_FREE_FAILURES = 2'd1;
    localparam t_cfg_idx CFG_DELAY_STEP    = 2'd2;
    localparam t_cfg_idx CFG_MAX_DELAY     = 2'd3;

    // Configuration reset values
    localparam logic        RST_ENABLED       = 1'b0;
    localparam logic [7:0]  RST_FREE_FAILURES = 8'd3;
    localparam logic [31:0] RST_DELAY_STEP    = 32'd300_000;
    localparam logic [31:0] RST_MAX_DELAY     = 32'd86_400_000;

    typedef struct packed {
        t_opcode          opcode;
        logic [NOW_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [31:0] remaining_ms;
        logic        locked;
        logic [30:0] failure_count;
    } t_out_item;

    // Core -> delay tracker
    typedef struct packed {
        logic advance;   // failure counted, count moves up by one
        logic clear;     // count returns to zero
    } t_dly_ctl;

    // Delay tracker -> core
    typedef struct packed {
        logic        busy;     // recomputing after reset or a register write
        logic [31:0] d_cur;    // capped delay for the current count
        logic [31:0] d_next;   // capped delay for the count plus one
    } t_dly_sts;

endpackage

`default_nettype wire

[hdl/falt_if.sv]
// Valid/ready stream interface for the lockout timer, payload type as a
// parameter. No dependencies.
`default_nettype none

interface falt_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/falt_delay.sv]
// Delay tracker: keeps the capped delay for the current and the next failure
// count, stepped by additions, rebuilt by one multiply after reset/config.
// Depends on falt_pkg.
`default_nettype none

module falt_delay (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [30:0]       i_fail_count,
    input  wire logic [7:0]        i_free_failures,
    input  wire logic [31:0]       i_delay_step,
    input  wire logic [31:0]       i_max_delay,
    input  wire falt_pkg::t_dly_ctl i_ctl,
    output falt_pkg::t_dly_sts     o_sts
);
    import falt_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_LOAD = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [63:0] r_prod;    // steps(count+1) * step, from the multiplier
    logic [63:0] r_pnext;   // uncapped delay for count+1
    logic [31:0] r_dcur;
    logic [31:0] r_dnext;

    logic [31:0] w_c2;
    logic        w_above;
    logic [31:0] w_k;
    logic [63:0] w_mul;
    logic [63:0] w_adv_p;
    logic [64:0] w_sub;
    logic [63:0] w_clr_p;
    logic [31:0] w_clr_dcur;

    function automatic logic [31:0] cap(input logic [63:0] p, input logic [31:0] m);
        return (p > {32'd0, m}) ? m : p[31:0];
    endfunction

    // count + 2 >= free_failures: count+1 is at or past the threshold
    assign w_c2    = {1'b0, i_fail_count} + 32'd2;
    assign w_above = w_c2 >= {24'd0, i_free_failures};
    assign w_k     = w_above ? (w_c2 - {24'd0, i_free_failures}) : '0;
    assign w_mul   = {32'd0, w_k} * {32'd0, i_delay_step};

    assign w_adv_p = w_above ? (r_pnext + {32'd0, i_delay_step}) : '0;
    assign w_sub   = {1'b0, r_prod} - {33'd0, i_delay_step};

    always_comb begin
        priority if (i_free_failures == 8'd0) begin
            w_clr_p = {31'd0, i_delay_step, 1'b0};
        end else if (i_free_failures == 8'd1) begin
            w_clr_p = {32'd0, i_delay_step};
        end else begin
            w_clr_p = '0;
        end
    end

    assign w_clr_dcur = (i_free_failures == 8'd0) ?
                        cap({32'd0, i_delay_step}, i_max_delay) : '0;

    always_comb begin
        unique case (r_phase)
            PH_MUL:  n_phase = PH_LOAD;
            PH_LOAD: n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
        if (i_cfg_we) begin
            n_phase = PH_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MUL;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_MUL) begin
            r_prod <= w_mul;
        end
        priority if (r_phase == PH_LOAD) begin
            r_pnext <= r_prod;
            r_dnext <= cap(r_prod, i_max_delay);
            r_dcur  <= w_sub[64] ? '0 : cap(w_sub[63:0], i_max_delay);
        end else if (i_ctl.advance) begin
            r_dcur  <= r_dnext;
            r_pnext <= w_adv_p;
            r_dnext <= cap(w_adv_p, i_max_delay);
        end else if (i_ctl.clear) begin
            r_dcur  <= w_clr_dcur;
            r_pnext <= w_clr_p;
            r_dnext <= cap(w_clr_p, i_max_delay);
        end else begin
            r_dcur  <= r_dcur;
        end
    end

    assign o_sts.busy   = r_phase != PH_IDLE;
    assign o_sts.d_cur  = r_dcur;
    assign o_sts.d_next = r_dnext;

endmodule

`default_nettype wire

[hdl/failed_attempt_lockout_timer_core.sv]
// Failed-attempt lockout timer, top level. Depends on falt_pkg, falt_if and
// falt_delay.
`default_nettype none

// Lockout timer against guessing attacks. Each input item carries an opcode
// (query, record failure, reset failures) and the current time in ms; each
// item yields exactly one result item with the remaining lockout time, a
// locked flag and the failure count after the event. Throughput is one item
// per clock while the output is not stalled and the tracker is not busy: an
// item is registered in the input stage, where the whole update is done, and
// its result is then registered in the output register, which lets the next
// item enter the input stage while a result waits. The delay for the current
// and next count is kept precomputed by the delay tracker, so the per-item
// path is only adds and compares. After reset, and after every configuration
// write, the tracker rebuilds those delays with one multiply and then one
// load; input ready is low during that time and during the write cycle. Only
// the low TIME_BITS bits of now_ms are used (TIME_BITS 32..48).
module failed_attempt_lockout_timer_core #(
    parameter int TIME_BITS = falt_pkg::TIME_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    falt_if.sink                        i_in,
    falt_if.source                      o_out,
    input  wire logic                   i_cfg_we,
    input  wire falt_pkg::t_cfg_idx     i_cfg_idx,
    input  wire logic [31:0]            i_cfg_data
);
    import falt_pkg::*;

    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // configuration
    logic        r_enabled;
    logic [7:0]  r_free_failures;
    logic [31:0] r_delay_step;
    logic [31:0] r_max_delay;

    // lockout state
    logic [30:0]          r_count, n_count;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;

    // input stage and output register
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      w_out_free;
    logic      w_fire;
    logic      w_accept;

    t_dly_ctl  w_ctl;
    t_dly_sts  w_sts;

    logic [TIME_BITS-1:0] w_now;
    logic                 w_at_max;
    logic [31:0]          w_d_rec;
    logic [31:0]          w_d_sel;
    logic [TIME_BITS:0]   w_sum;
    logic                 w_sat;
    logic [TIME_BITS-1:0] w_new_deadline;
    logic [TIME_BITS-1:0] w_headroom;
    logic [31:0]          w_rem_restart;
    logic [TIME_BITS-1:0] w_diff;
    logic [31:0]          w_rem_live;
    logic [31:0]          w_rem;

    // ---------------- handshakes ----------------
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_fire      = r_in_valid && w_out_free;
    assign i_in.ready  = (!r_in_valid || w_out_free) && !w_sts.busy && !i_cfg_we;
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled       <= RST_ENABLED;
            r_free_failures <= RST_FREE_FAILURES;
            r_delay_step    <= RST_DELAY_STEP;
            r_max_delay     <= RST_MAX_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLED:       r_enabled       <= i_cfg_data[0];
                CFG_FREE_FAILURES: r_free_failures <= i_cfg_data[7:0];
                CFG_DELAY_STEP:    r_delay_step    <= i_cfg_data;
                CFG_MAX_DELAY:     r_max_delay     <= i_cfg_data;
                default:           r_enabled       <= r_enabled;
            endcase
        end
    end

    // ---------------- delay tracker ----------------
    assign w_ctl.advance = w_fire && (r_in.opcode == OP_FAIL) && r_enabled && !w_at_max;
    assign w_ctl.clear   = w_fire && (r_in.opcode == OP_RESET);

    falt_delay u_delay (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_fail_count    (r_count),
        .i_free_failures (r_free_failures),
        .i_delay_step    (r_delay_step),
        .i_max_delay     (r_max_delay),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts)
    );

    // ---------------- per-item update ----------------
    assign w_now    = TIME_BITS'(r_in.now_ms);
    assign w_at_max = r_count == COUNT_MAX;
    // a saturated count keeps its delay
    assign w_d_rec  = w_at_max ? w_sts.d_cur : w_sts.d_next;
    assign w_d_sel  = (r_in.opcode == OP_FAIL) ? w_d_rec : w_sts.d_cur;

    // New lockout from now: deadline saturates at the top of the time range,
    // and then the remaining time is whatever headroom is left.
    assign w_sum          = {1'b0, w_now} + (TIME_BITS+1)'(w_d_sel);
    assign w_sat          = w_sum[TIME_BITS];
    assign w_new_deadline = w_sat ? TMAX : w_sum[TIME_BITS-1:0];
    assign w_headroom     = TMAX - w_now;
    assign w_rem_restart  = w_sat ? w_headroom[31:0] : w_d_sel;

    // Pending lockout, still running
    assign w_diff     = r_deadline - w_now;
    assign w_rem_live = (w_diff > TIME_BITS'(U32_MAX)) ? U32_MAX : w_diff[31:0];

    always_comb begin
        n_count    = r_count;
        n_start    = r_start;
        n_deadline = r_deadline;
        w_rem      = '0;
        unique case (r_in.opcode)
            OP_QUERY: begin
                if (r_enabled && (r_deadline != '0)) begin
                    priority if (w_sts.d_cur == '0) begin
                        n_start    = '0;
                        n_deadline = '0;
                    end else if (w_now < r_start) begin
                        // clock went backwards: full delay from now
                        n_start    = w_now;
                        n_deadline = w_new_deadline;
                        w_rem      = w_rem_restart;
                    end else if (w_now >= r_deadline) begin
                        n_start    = '0;
                        n_deadline = '0;
                    end else begin
                        w_rem      = w_rem_live;
                    end
                end
            end
            OP_FAIL: begin
                if (r_enabled) begin
                    n_count = w_at_max ? r_count : (r_count + 31'd1);
                    if (w_d_rec != '0) begin
                        n_start    = w_now;
                        n_deadline = w_new_deadline;
                        w_rem      = w_rem_restart;
                    end else begin
                        n_start    = '0;
                        n_deadline = '0;
                    end
                end
            end
            OP_RESET: begin
                n_count    = '0;
                n_start    = '0;
                n_deadline = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_start     <= '0;
            r_deadline  <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_start     <= n_start;
                r_deadline  <= n_deadline;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in.data;
        end
        if (w_fire) begin
            r_out.remaining_ms  <= w_rem;
            r_out.locked        <= w_rem != '0;
            r_out.failure_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/falt_checker.sv]
// Port-level checker for the lockout timer and its bind to the top level.
// Depends on falt_pkg and failed_attempt_lockout_timer_core.
`default_nettype none

module falt_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire falt_pkg::t_out_item i_out_data,
    input  wire logic                i_cfg_we
);
    import falt_pkg::*;

    // locked flag agrees with the remaining time
    a_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.locked == (i_out_data.remaining_ms != '0)))
        else $error("locked flag disagrees with remaining_ms");

    // no item taken while delays are being rebuilt
    a_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!i_rst_n) || $past(i_cfg_we)) |-> !i_in_ready)
        else $error("input ready during delay rebuild");

    // every new result comes from an item taken earlier into the input stage
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a matching input item");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind failed_attempt_lockout_timer_core falt_checker u_falt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data),
    .i_cfg_we    (i_cfg_we)
);

`default_nettype wire
